/* sv/srp_pkg.sv */
// Shared types, constants and stage numbers of the surround pixel pipeline.
`timescale 1ns / 1ps
package srp_pkg;

	localparam int PIXEL_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int GAMMA_W   = 15;
	localparam int CFG_IDX_W = 1;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 15'd12780;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAMMA   = 1'b0,
		REG_INVERSE = 1'b1
	} cfg_reg_t;

	// Rec.2020 luminance weights, Q16
	localparam int COEF_R = 17216;
	localparam int COEF_G = 44433;
	localparam int COEF_B = 3886;

	localparam int ONE_Q14 = 16384;
	localparam int ONE_Q28 = 1 << 28;
	localparam int ONE_Q30 = 1 << 30;
	localparam int HALF_Q30 = 1 << 29;

	localparam int EW      = 30;     // exponent e, signed Q14
	localparam int KW      = 7;      // integer part of log2, signed
	localparam int FRACL   = 16;     // log2 fraction bits
	localparam int LW      = KW + FRACL;
	localparam int MW      = 31;     // log2 mantissa, Q30 in [1,2)
	localparam int XMW     = 32;     // exp2 mantissa, Q30
	localparam int NCW     = 8;      // clamped power integer part, signed
	localparam int EXP_LN2_K = 45426;

	localparam int DIV_STEPS  = 15;  // two quotient bits per stage
	localparam int LOG_STEPS  = 16;
	localparam int EXP_N      = 8;

	// stage numbers
	localparam int ST_LUM     = 2;
	localparam int ST_NORM    = 4;
	localparam int ST_E       = DIV_STEPS + 1;
	localparam int ST_LOG_OUT = ST_NORM + LOG_STEPS;
	localparam int ST_MUL     = ST_LOG_OUT + 1;
	localparam int ST_SPLIT   = ST_MUL + 1;
	localparam int ST_EXP_OUT = ST_SPLIT + EXP_N + 1;
	localparam int ST_LAST    = ST_EXP_OUT + 3;

	// round(2^30 * 2^(2^-(i+1))) for the top fraction bits
	localparam logic [MW-1:0] EXP_STEPS [EXP_N] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434107, 31'd1079572136, 31'd1076653033
	};

endpackage

/* sv/srp_recip.sv */
// Pipelined exponent unit: e = gamma-1 or round(1/gamma)-1 in Q14, two quotient bits a stage.
`timescale 1ns / 1ps
module srp_recip import srp_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [GAMMA_W-1:0]    gamma,
	input  logic                  inverse_mode,
	output logic signed [EW-1:0]  expo
);

	localparam int QW = 2 * DIV_STEPS;

	function automatic logic [GAMMA_W+1:0] div2(input logic [GAMMA_W-1:0] rem,
			input logic [GAMMA_W-1:0] d, input logic [1:0] nb);
		logic [GAMMA_W:0]   r;
		logic [GAMMA_W-1:0] r1;
		logic               q1;
		logic               q0;
		r  = {rem, nb[1]};
		q1 = (r >= {1'b0, d});
		r1 = q1 ? GAMMA_W'(r - {1'b0, d}) : r[GAMMA_W-1:0];
		r  = {r1, nb[0]};
		q0 = (r >= {1'b0, d});
		r1 = q0 ? GAMMA_W'(r - {1'b0, d}) : r[GAMMA_W-1:0];
		return {r1, q1, q0};
	endfunction

	logic [GAMMA_W-1:0] rem_s [1:DIV_STEPS];
	logic [GAMMA_W-1:0] d_s   [1:DIV_STEPS];
	logic [GAMMA_W-1:0] gam_s [1:DIV_STEPS];
	logic               inv_s [1:DIV_STEPS];
	logic [QW-1:0]      num_s [1:DIV_STEPS];
	logic [QW-1:0]      q_s   [1:DIV_STEPS];
	logic [GAMMA_W+1:0] st_c  [1:DIV_STEPS];
	logic signed [EW-1:0] e_s [ST_E:ST_LOG_OUT];

	logic [GAMMA_W-1:0] gg_c;
	logic [QW-1:0]      num_c;

	// a gamma of zero divides as one LSB
	assign gg_c  = (gamma == '0) ? GAMMA_W'(1) : gamma;
	assign num_c = QW'(ONE_Q28) + QW'(gg_c >> 1);
	assign st_c[1] = div2('0, gg_c, num_c[QW-1 -: 2]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= st_c[1][GAMMA_W+1:2];
			q_s[1]   <= QW'(st_c[1][1:0]);
			num_s[1] <= num_c << 2;
			d_s[1]   <= gg_c;
			inv_s[1] <= inverse_mode;
			gam_s[1] <= gamma;
		end
	end

	for (genvar j = 2; j <= DIV_STEPS; j++) begin : g_div
		assign st_c[j] = div2(rem_s[j-1], d_s[j-1], num_s[j-1][QW-1 -: 2]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= st_c[j][GAMMA_W+1:2];
				q_s[j]   <= {q_s[j-1][QW-3:0], st_c[j][1:0]};
				num_s[j] <= num_s[j-1] << 2;
				d_s[j]   <= d_s[j-1];
				inv_s[j] <= inv_s[j-1];
				gam_s[j] <= gam_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s[ST_E] <= inv_s[DIV_STEPS] ? EW'(q_s[DIV_STEPS]) - EW'(ONE_Q14)
			                              : EW'(gam_s[DIV_STEPS]) - EW'(ONE_Q14);
		end
	end

	// hold e until the log result catches up
	for (genvar j = ST_E + 1; j <= ST_LOG_OUT; j++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				e_s[j] <= e_s[j-1];
			end
		end
	end

	assign expo = e_s[ST_LOG_OUT];

endmodule

/* sv/srp_log2.sv */
// Pipelined log2 of the luminance sum: two normalize stages, then one squaring step a stage.
`timescale 1ns / 1ps
module srp_log2 import srp_pkg::*; #(
	parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [PIXEL_WIDTH+14:0]      lum,
	output logic signed [LW-1:0]         log_l
);

	localparam int SW    = PIXEL_WIDTH + 15;
	localparam int LZB   = $clog2(SW);
	localparam int LZ_LO = LZB / 2;
	localparam int KOFF  = SW - 1 - FRAC_BITS - 16;

	logic [SW-1:0]    v3_c;
	logic [LZB-1:0]   lz3_c;
	logic [SW-1:0]    v3_s3;
	logic [LZB-1:0]   lz3_s3;
	logic [SW-1:0]    v4_c;
	logic [LZB-1:0]   lz4_c;
	logic [SW+MW-1:0] jw_c;

	logic [MW-1:0]    m_s    [ST_NORM:ST_LOG_OUT];
	logic [FRACL-1:0] frac_s [ST_NORM:ST_LOG_OUT];
	logic [KW-1:0]    kk_s   [ST_NORM:ST_LOG_OUT];

	// leading-zero search, upper shift steps
	always_comb begin
		v3_c  = lum;
		lz3_c = '0;
		for (int b = LZB - 1; b >= LZ_LO; b--) begin
			if ((v3_c >> (SW - (1 << b))) == '0) begin
				v3_c     = v3_c << (1 << b);
				lz3_c[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v3_s3  <= v3_c;
			lz3_s3 <= lz3_c;
		end
	end

	// lower shift steps
	always_comb begin
		v4_c  = v3_s3;
		lz4_c = lz3_s3;
		for (int b = LZ_LO - 1; b >= 0; b--) begin
			if ((v4_c >> (SW - (1 << b))) == '0) begin
				v4_c     = v4_c << (1 << b);
				lz4_c[b] = 1'b1;
			end
		end
	end

	assign jw_c = {v4_c, MW'(0)};

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[ST_NORM]    <= jw_c[SW+MW-1 -: MW];
			frac_s[ST_NORM] <= '0;
			kk_s[ST_NORM]   <= KW'(KOFF) - KW'(lz4_c);
		end
	end

	for (genvar j = ST_NORM + 1; j <= ST_LOG_OUT; j++) begin : g_sq
		logic [2*MW-1:0] sq_c;
		logic [MW:0]     t_c;
		assign sq_c = (2*MW)'(m_s[j-1]) * (2*MW)'(m_s[j-1]);
		assign t_c  = sq_c[2*MW-1:MW-1];
		always_ff @(posedge clk) begin
			if (en) begin
				// square, then halve when the mantissa reaches two
				m_s[j]    <= t_c[MW] ? t_c[MW:1] : t_c[MW-1:0];
				frac_s[j] <= {frac_s[j-1][FRACL-2:0], t_c[MW]};
				kk_s[j]   <= kk_s[j-1];
			end
		end
	end

	assign log_l = {kk_s[ST_LOG_OUT], frac_s[ST_LOG_OUT]};

endmodule

/* sv/srp_exp2.sv */
// Pipelined power: x = e*log2(Y), split into integer and fraction, 2^fraction by table steps.
`timescale 1ns / 1ps
module srp_exp2 import srp_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [LW-1:0]   log_l,
	input  logic signed [EW-1:0]   expo,
	output logic [XMW-1:0]         mant,
	output logic signed [NCW-1:0]  pow_n
);

	localparam int PW_E = EW + LW;
	localparam int ST_STEP0 = ST_SPLIT + 1;
	localparam int ST_STEPN = ST_SPLIT + EXP_N;
	localparam logic signed [PW_E-1:0] NMAX = PW_E'(127);
	localparam logic signed [PW_E-1:0] NMIN = -PW_E'(128);

	logic signed [PW_E-1:0] p_s21;
	logic signed [PW_E-1:0] x_c;
	logic signed [PW_E-1:0] n_c;
	logic signed [NCW-1:0]  nc_c;

	logic [XMW-1:0]        m_s   [ST_SPLIT:ST_STEPN];
	logic [FRACL-1:0]      fr_s  [ST_SPLIT:ST_STEPN];
	logic signed [NCW-1:0] n_s   [ST_SPLIT:ST_STEPN];
	logic [XMW-1:0]        lin_s [ST_STEP0:ST_STEPN];
	logic [23:0]           lp_c;
	logic [XMW+XMW-1:0]    fin_c;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s21 <= PW_E'(expo) * PW_E'(log_l);
		end
	end

	// floor((e*L + 2^13) / 2^14), then floor of that over 2^16
	assign x_c = (p_s21 + PW_E'(8192)) >>> 14;
	assign n_c = x_c >>> FRACL;

	always_comb begin
		if (n_c > NMAX) begin
			nc_c = NCW'(NMAX);
		end else if (n_c < NMIN) begin
			nc_c = NCW'(NMIN);
		end else begin
			nc_c = NCW'(n_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[ST_SPLIT]  <= XMW'(ONE_Q30);
			fr_s[ST_SPLIT] <= x_c[FRACL-1:0];
			n_s[ST_SPLIT]  <= nc_c;
		end
	end

	assign lp_c = 24'(fr_s[ST_SPLIT][7:0]) * 24'(EXP_LN2_K);

	for (genvar i = 0; i < EXP_N; i++) begin : g_step
		localparam int J = ST_STEP0 + i;
		logic [XMW+MW-1:0] pr_c;
		logic [63:0]       rd_c;
		assign pr_c = (XMW+MW)'(m_s[J-1]) * (XMW+MW)'(EXP_STEPS[i]);
		assign rd_c = (64'(pr_c) + 64'(HALF_Q30)) >> 30;
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[J]  <= fr_s[J-1][FRACL-1-i] ? rd_c[XMW-1:0] : m_s[J-1];
				fr_s[J] <= fr_s[J-1];
				n_s[J]  <= n_s[J-1];
			end
		end
	end

	// linear factor for the low fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			lin_s[ST_STEP0] <= XMW'(ONE_Q30) + XMW'(lp_c >> 2);
		end
	end

	for (genvar j = ST_STEP0 + 1; j <= ST_STEPN; j++) begin : g_lin
		always_ff @(posedge clk) begin
			if (en) begin
				lin_s[j] <= lin_s[j-1];
			end
		end
	end

	assign fin_c = (XMW+XMW)'(m_s[ST_STEPN]) * (XMW+XMW)'(lin_s[ST_STEPN]);

	always_ff @(posedge clk) begin
		if (en) begin
			mant  <= XMW'((fin_c + (XMW+XMW)'(HALF_Q30)) >> 30);
			pow_n <= n_s[ST_STEPN];
		end
	end

endmodule

/* sv/rec2100_surround_pixel.sv */
// Rec.2100 surround adjustment of an RGB pixel stream: luminance, Y^e scaling, saturation.
//
// One pixel enters per clock while in_stall is low. The depth
// is set by the 16-step log2 squaring chain, the 8 table steps of the power, and the
// multiplier stages around them; the inverse-gamma reciprocal runs alongside in 15 stages
// at two quotient bits each. A stall on the output freezes the whole pipeline, so in_stall
// rises only while a finished pixel waits on out_stall. Pixels with luminance at or below
// zero pass through unchanged. Write gamma (index 0, Q1.14) and inverse_mode (index 1)
// only while the pipeline is empty.
`timescale 1ns / 1ps
module rec2100_surround_pixel import srp_pkg::*; #(
	parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [PIXEL_WIDTH-1:0] red_in,
	input  logic signed [PIXEL_WIDTH-1:0] green_in,
	input  logic signed [PIXEL_WIDTH-1:0] blue_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [PIXEL_WIDTH-1:0] red_out,
	output logic signed [PIXEL_WIDTH-1:0] green_out,
	output logic signed [PIXEL_WIDTH-1:0] blue_out,
	input  logic                          write_en,
	input  logic [CFG_IDX_W-1:0]          write_index,
	input  logic [GAMMA_W-1:0]            write_data
);

	localparam int PW  = PIXEL_WIDTH;
	localparam int PSW = PW + 18;
	localparam int SW  = PW + 15;
	localparam int AW  = PW + XMW;
	localparam logic [AW-1:0] CAP    = AW'(1) << (PW - 1);
	localparam logic [AW-1:0] CAP_M1 = CAP - AW'(1);

	function automatic logic [AW-1:0] scale_shift(input logic [AW-1:0] a,
			input logic signed [NCW-1:0] n);
		logic signed [NCW:0] sh;
		logic [NCW:0]        ls;
		logic [5:0]          shr;
		logic [AW-1:0]       t;
		logic [AW-1:0]       r;
		sh  = (NCW+1)'(30) - (NCW+1)'(n);
		ls  = (NCW+1)'(-sh);
		shr = 6'(sh - (NCW+1)'(1));
		t   = a >> shr;
		if (sh > 0) begin
			if (sh >= 63) begin
				r = '0;
			end else begin
				r = AW'(({1'b0, t} + (AW+1)'(1)) >> 1);
			end
		end else if (sh == 0) begin
			r = a;
		end else if (a == '0) begin
			r = '0;
		end else if (ls >= 40 || a > (CAP >> ls)) begin
			r = CAP;
		end else begin
			r = a << ls;
		end
		return r;
	endfunction

	logic               adv;
	logic [GAMMA_W-1:0] gamma_q;
	logic               inverse_mode_q;
	logic [1:ST_LAST]   vld_s;

	logic signed [PW-1:0]  pix_s [1:ST_LAST-1][0:2];
	logic                  pos_s [ST_LUM:ST_LAST-1];
	logic signed [PSW-1:0] pr_s1 [0:2];
	logic signed [PSW-1:0] sum_c;
	logic [SW-1:0]         lum_s2;

	logic signed [LW-1:0]  log_l;
	logic signed [EW-1:0]  expo;
	logic [XMW-1:0]        mant;
	logic signed [NCW-1:0] pow_n;

	logic [PW-1:0]         mag_c  [0:2];
	logic [AW-1:0]         a_s32  [0:2];
	logic signed [NCW-1:0] n_s32;
	logic [AW-1:0]         r_s33  [0:2];
	logic signed [PW-1:0]  out_c  [0:2];
	logic signed [PW-1:0]  out_s34 [0:2];

	// a full output that is not taken freezes every stage
	assign adv       = !(vld_s[ST_LAST] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_s[ST_LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q        <= GAMMA_RESET;
			inverse_mode_q <= 1'b0;
		end else if (write_en) begin
			case (cfg_reg_t'(write_index))
				REG_GAMMA:   gamma_q        <= write_data;
				REG_INVERSE: inverse_mode_q <= write_data[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {in_valid, vld_s[1:ST_LAST-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s[1][0] <= red_in;
			pix_s[1][1] <= green_in;
			pix_s[1][2] <= blue_in;
			pr_s1[0]    <= PSW'(red_in) * PSW'(COEF_R);
			pr_s1[1]    <= PSW'(green_in) * PSW'(COEF_G);
			pr_s1[2]    <= PSW'(blue_in) * PSW'(COEF_B);
		end
	end

	for (genvar j = 2; j <= ST_LAST - 1; j++) begin : g_pix
		always_ff @(posedge clk) begin
			if (adv) begin
				pix_s[j] <= pix_s[j-1];
			end
		end
	end

	assign sum_c = pr_s1[0] + pr_s1[1] + pr_s1[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s[ST_LUM] <= !sum_c[PSW-1] && (sum_c != '0);
			lum_s2        <= sum_c[SW-1:0];
		end
	end

	for (genvar j = ST_LUM + 1; j <= ST_LAST - 1; j++) begin : g_pos
		always_ff @(posedge clk) begin
			if (adv) begin
				pos_s[j] <= pos_s[j-1];
			end
		end
	end

	srp_recip u_recip (
		.clk          (clk),
		.en           (adv),
		.gamma        (gamma_q),
		.inverse_mode (inverse_mode_q),
		.expo         (expo)
	);

	srp_log2 #(
		.PIXEL_WIDTH (PIXEL_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_log2 (
		.clk   (clk),
		.en    (adv),
		.lum   (lum_s2),
		.log_l (log_l)
	);

	srp_exp2 u_exp2 (
		.clk   (clk),
		.en    (adv),
		.log_l (log_l),
		.expo  (expo),
		.mant  (mant),
		.pow_n (pow_n)
	);

	for (genvar c = 0; c < 3; c++) begin : g_chan
		assign mag_c[c] = pix_s[ST_EXP_OUT][c][PW-1] ? (~pix_s[ST_EXP_OUT][c] + PW'(1))
		                                             : pix_s[ST_EXP_OUT][c];

		always_ff @(posedge clk) begin
			if (adv) begin
				a_s32[c] <= AW'(mag_c[c]) * AW'(mant);
				r_s33[c] <= scale_shift(a_s32[c], n_s32);
			end
		end

		always_comb begin
			if (!pos_s[ST_LAST-1]) begin
				out_c[c] = pix_s[ST_LAST-1][c];
			end else if (pix_s[ST_LAST-1][c][PW-1]) begin
				out_c[c] = PW'(~((r_s33[c] > CAP) ? CAP : r_s33[c]) + AW'(1));
			end else begin
				out_c[c] = PW'((r_s33[c] > CAP_M1) ? CAP_M1 : r_s33[c]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				out_s34[c] <= out_c[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s32 <= pow_n;
		end
	end

	assign red_out   = out_s34[0];
	assign green_out = out_s34[1];
	assign blue_out  = out_s34[2];

	ap_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("valid bits moved while the pipeline was stalled");

	ap_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[ST_LAST-1] |=> out_valid)
		else $error("request lost on its way to the output register");

	ap_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[ST_LAST-1] && !pos_s[ST_LAST-1]
		|=> red_out == $past(pix_s[ST_LAST-1][0]) && blue_out == $past(pix_s[ST_LAST-1][2]))
		else $error("non-positive luminance pixel was altered");

endmodule

/* tb/rec2100_surround_pixel_tb.sv */
// Self-checking testbench for the Rec.2100 surround pixel pipeline.
`timescale 1ns / 1ps
module rec2100_surround_pixel_tb;
	import srp_pkg::*;

	localparam int PW = 24;
	localparam int FB = 16;
	localparam int PIPE_DEPTH = 34;

	typedef struct packed {
		logic signed [PW-1:0] red;
		logic signed [PW-1:0] green;
		logic signed [PW-1:0] blue;
	} rgb_t;

	class surround_scoreboard;
		rgb_t pending[$];
		logic [GAMMA_W-1:0] gamma_q14;
		bit inverse;
		int errors;

		function new();
			gamma_q14 = GAMMA_RESET;
			inverse = 0;
			errors = 0;
		endfunction

		static function longint log2_lum(longint unsigned s);
			int msb;
			longint unsigned mant;
			longint frac;
			msb = 0;
			frac = 0;
			for (int i = 0; i < 64; i++)
				if (s[i]) msb = i;
			mant = (msb > 30) ? (s >> (msb - 30)) : (s << (30 - msb));
			for (int i = 0; i < 16; i++) begin
				mant = (mant * mant) >> 30;
				frac = frac << 1;
				if (mant >= (64'd2 << 30)) begin
					mant = mant >> 1;
					frac = frac | 1;
				end
			end
			return longint'(msb - FB - 16) * 65536 + frac;
		endfunction

		static function longint unsigned pow2_frac(logic [15:0] fr);
			longint unsigned steps [8] = '{64'd1518500250, 64'd1276901417, 64'd1170923762,
				64'd1121280436, 64'd1097253708, 64'd1085434107, 64'd1079572136,
				64'd1076653033};
			longint unsigned m, lin;
			m = 64'd1 << 30;
			for (int i = 0; i < 8; i++)
				if (fr[15-i]) m = (m * steps[i] + (64'd1 << 29)) >> 30;
			lin = (64'd1 << 30) + ((longint'(fr[7:0]) * 45426) >> 2);
			return (m * lin + (64'd1 << 29)) >> 30;
		endfunction

		static function logic [PW-1:0] scale_channel(longint p, longint unsigned m, longint n);
			longint unsigned cap, a;
			longint sh;
			bit neg;
			cap = 64'd1 << (PW - 1);
			neg = p < 0;
			a = longint'(neg ? -p : p) * m;
			sh = 30 - n;
			if (sh > 0) begin
				a = (sh >= 63) ? 0 : ((a + (64'd1 << (sh - 1))) >> sh);
			end else if (sh < 0 && a != 0) begin
				if (-sh >= 40 || a > (cap >> (-sh))) a = cap;
				else a = a << (-sh);
			end
			if (!neg && a > cap - 1) a = cap - 1;
			if (neg && a > cap) a = cap;
			return PW'(neg ? (0 - a) : a);
		endfunction

		// predict the result of one accepted pixel
		function void note_pixel(rgb_t px);
			longint r, g, b, s, e, lg, x, n;
			longint unsigned gg, m;
			rgb_t res;
			r = px.red;
			g = px.green;
			b = px.blue;
			s = 17216 * r + 44433 * g + 3886 * b;
			if (s <= 0) begin
				pending.push_back(px);
				return;
			end
			if (inverse) begin
				gg = (gamma_q14 == 0) ? 1 : gamma_q14;
				e = longint'(((64'd1 << 28) + gg / 2) / gg) - 16384;
			end else begin
				e = longint'(gamma_q14) - 16384;
			end
			lg = log2_lum(s);
			x = (e * lg + 8192) >>> 14;
			n = x >>> 16;
			m = pow2_frac(16'(x - n * 65536));
			res.red = scale_channel(r, m, n);
			res.green = scale_channel(g, m, n);
			res.blue = scale_channel(b, m, n);
			pending.push_back(res);
		endfunction

		function void check_pixel(rgb_t got);
			rgb_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel %h %h %h", $time, got.red, got.green, got.blue);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.red !== want.red) begin
				$display("%0t: red expected %h got %h", $time, want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green expected %h got %h", $time, want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue expected %h got %h", $time, want.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, write_en;
	logic signed [PW-1:0] red_in, green_in, blue_in, red_out, green_out, blue_out;
	logic [CFG_IDX_W-1:0] write_index;
	logic [GAMMA_W-1:0] write_data;

	surround_scoreboard sb = new();
	int gap_left = 0;
	bit hold_done = 0;

	rec2100_surround_pixel uut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel('{red_out, green_out, blue_out});
		if (arst_n && in_valid && !in_stall)
			sb.note_pixel('{red_in, green_in, blue_in});
	end

	// receiver: free-running, random, periodic stretches, one long hold-off
	initial begin
		int mode, len;
		out_stall = 0;
		@(posedge arst_n);
		repeat (60) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 40);
			if (!hold_done && mode == 3) begin
				hold_done = 1;
				out_stall <= 1;
				repeat (120) @(posedge clk);
			end else begin
				for (int i = 0; i < len; i++) begin
					case (mode)
						0: out_stall <= 0;
						1: out_stall <= $urandom_range(0, 1);
						default: out_stall <= (i % 3 == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_pixel(logic [PW-1:0] r, logic [PW-1:0] g, logic [PW-1:0] b);
		if (gap_left == 0) begin
			gap_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		gap_left--;
		in_valid <= 1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [GAMMA_W-1:0] val);
		write_en <= 1;
		write_index <= idx;
		write_data <= val;
		@(posedge clk);
		write_en <= 0;
		if (idx == REG_GAMMA) sb.gamma_q14 = val;
		else sb.inverse = val[0];
	endtask

	function automatic logic [PW-1:0] rand_chan();
		int sel;
		logic [PW-1:0] v;
		sel = $urandom_range(0, 9);
		v = PW'($urandom);
		// mostly positive channels of varied magnitude so luminance is usually above zero
		if (sel < 6) return v >> $urandom_range(1, PW - 1);
		if (sel < 8) return v;
		return -(v >> $urandom_range(4, PW - 1));
	endfunction

	task automatic random_pixels(int count);
		for (int i = 0; i < count; i++)
			send_pixel(rand_chan(), rand_chan(), rand_chan());
	endtask

	initial begin
		logic [PW-1:0] vmax, vmin;
		vmax = {1'b0, {(PW-1){1'b1}}};
		vmin = {1'b1, {(PW-1){1'b0}}};
		arst_n = 0;
		in_valid = 0;
		red_in = 0;
		green_in = 0;
		blue_in = 0;
		write_en = 0;
		write_index = REG_GAMMA;
		write_data = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// edge pixels at reset configuration
		send_pixel(0, 0, 0);
		send_pixel(vmax, vmax, vmax);
		send_pixel(vmin, vmin, vmin);
		send_pixel(vmax, 0, 0);
		send_pixel(0, vmax, 0);
		send_pixel(0, 0, vmax);
		send_pixel(vmin, vmax, vmin);
		send_pixel(vmax, vmin, vmax);
		send_pixel(1, 1, 1);
		send_pixel(0, 1, 0);
		send_pixel(0, 0, 1);
		send_pixel(PW'(1 << FB), PW'(1 << FB), PW'(1 << FB));
		send_pixel(PW'(1 << FB), PW'(-(1 << FB)), PW'(1 << FB));
		send_pixel(PW'(-1), PW'(-1), PW'(-1));
		send_pixel(vmax, 1, vmin);
		send_pixel(1, vmax, 1);
		send_pixel(PW'(-3), 1, 100);
		random_pixels(40);

		drain();
		write_reg(REG_GAMMA, 1);
		random_pixels(40);
		drain();
		write_reg(REG_GAMMA, 15'h7fff);
		send_pixel(vmax, vmax, vmax);
		random_pixels(40);
		drain();
		write_reg(REG_GAMMA, 0);
		random_pixels(30);
		drain();
		write_reg(REG_INVERSE, 1);
		random_pixels(30);
		drain();
		write_reg(REG_GAMMA, 1);
		send_pixel(1, 1, 1);
		send_pixel(vmax, vmax, vmax);
		random_pixels(30);
		drain();
		write_reg(REG_GAMMA, 15'h7fff);
		random_pixels(40);
		drain();
		write_reg(REG_GAMMA, 16384);
		random_pixels(30);
		drain();
		write_reg(REG_GAMMA, GAMMA_RESET);
		random_pixels(40);
		for (int ph = 0; ph < 3; ph++) begin
			drain();
			write_reg(REG_INVERSE, GAMMA_W'($urandom_range(0, 1)));
			write_reg(REG_GAMMA, GAMMA_W'($urandom_range(0, 32767)));
			random_pixels(30);
		end
		drain();

		if (sb.errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/srp_pkg.sv
sv/srp_recip.sv
sv/srp_log2.sv
sv/srp_exp2.sv
sv/rec2100_surround_pixel.sv
tb/rec2100_surround_pixel_tb.sv
